[rtl/assert_macros.svh]
// assertion macros for the line generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DSL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSL_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DSL_ASSERT(label, clk, rst, prop, msg)
`define DSL_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[rtl/dsl_pkg.sv]
`default_nettype none
package dsl_pkg;

  localparam int unsigned COORD_BITS_DEF  = 10;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned DASH_SHIFT      = 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [1:0] STYLE_SOLID = 2'd0;
  localparam logic [1:0] STYLE_THICK = 2'd1;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

[rtl/dsl_front.sv]
`default_nettype none
module dsl_front import dsl_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned EntryW = 5 * COORD_BITS + 5
) (
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [1:0]            line_style,
  input  wire queue_status_t         q_status,
  output logic                       push,
  output logic [EntryW-1:0]          entry
);

  logic [COORD_BITS:0]   diff_x, diff_y;
  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] abs_x, abs_y, steps;
  logic [COORD_BITS:0]   mag_x, mag_y;

  // signed deltas, magnitudes and the major-axis step count
  always_comb begin
    diff_x = {1'b0, end_x} - {1'b0, start_x};
    diff_y = {1'b0, end_y} - {1'b0, start_y};
    neg_x  = diff_x[COORD_BITS];
    neg_y  = diff_y[COORD_BITS];
    mag_x  = neg_x ? (~diff_x + 1'b1) : diff_x;
    mag_y  = neg_y ? (~diff_y + 1'b1) : diff_y;
    abs_x  = mag_x[COORD_BITS-1:0];
    abs_y  = mag_y[COORD_BITS-1:0];
    steps  = (abs_x > abs_y) ? abs_x : abs_y;
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign entry    = {req_type, line_style, start_x, start_y, abs_x, abs_y, neg_x, neg_y, steps};

endmodule
`default_nettype wire

[rtl/dsl_queue.sv]
`default_nettype none
module dsl_queue import dsl_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output queue_status_t         status
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data      = slots[rd_ptr];
  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);

endmodule
`default_nettype wire

[rtl/dsl_back.sv]
`default_nettype none
`include "assert_macros.svh"
module dsl_back import dsl_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned EntryW = 5 * COORD_BITS + 5,
  localparam int unsigned PosW   = COORD_BITS + FRAC_BITS,
  localparam int unsigned IncW   = FRAC_BITS + 2,
  localparam int unsigned CntW   = $clog2(FRAC_BITS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [EntryW-1:0]     entry,
  input  wire queue_status_t         q_status,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       visible,
  output logic                       thick,
  output logic                       last
);

  logic                  h_kind;
  logic [1:0]            h_style;
  logic [COORD_BITS-1:0] h_sx, h_sy, h_ax, h_ay, h_steps;
  logic                  h_negx, h_negy;

  assign {h_kind, h_style, h_sx, h_sy, h_ax, h_ay, h_negx, h_negy, h_steps} = entry;

  back_state_t           state, state_next;
  logic                  active;
  logic [PosW-1:0]       pos_x, pos_y;
  logic [IncW-1:0]       step_x, step_y;
  logic [COORD_BITS:0]   point_index;
  logic [COORD_BITS-1:0] step_count;
  logic [1:0]            style_reg;
  logic                  neg_x, neg_y;
  logic [COORD_BITS:0]   rem_x, rem_y;
  logic [FRAC_BITS:0]    quo_x, quo_y;
  logic [CntW-1:0]       div_cnt;

  logic                  out_free, start_load, emit, div_last, is_last;
  logic                  bit_x, bit_y;
  logic [COORD_BITS:0]   newr_x, newr_y;
  logic [FRAC_BITS:0]    quo_x_next, quo_y_next;
  logic [IncW-1:0]       mag_x, mag_y;

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (point_index == {1'b0, step_count});

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    start_load = 1'b0;
    emit       = 1'b0;
    div_last   = 1'b0;
    case (state)
      ST_RUN: begin
        if (!q_status.empty) begin
          if (h_kind == REQ_LOAD) begin
            q_pop      = 1'b1;
            start_load = 1'b1;
          end else if (!active) begin
            q_pop = 1'b1;
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
          end
        end
      end
      ST_DIV: begin
        div_last = (div_cnt == '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (start_load) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // one quotient bit per cycle for each axis
  always_comb begin
    bit_x      = (step_count != '0) && (rem_x >= {1'b0, step_count});
    bit_y      = (step_count != '0) && (rem_y >= {1'b0, step_count});
    newr_x     = bit_x ? (rem_x - {1'b0, step_count}) : rem_x;
    newr_y     = bit_y ? (rem_y - {1'b0, step_count}) : rem_y;
    quo_x_next = {quo_x[FRAC_BITS-1:0], bit_x};
    quo_y_next = {quo_y[FRAC_BITS-1:0], bit_y};
    mag_x      = {1'b0, quo_x_next};
    mag_y      = {1'b0, quo_y_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (start_load) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_load) begin
      pos_x       <= {h_sx, {FRAC_BITS{1'b0}}};
      pos_y       <= {h_sy, {FRAC_BITS{1'b0}}};
      point_index <= '0;
      step_count  <= h_steps;
      style_reg   <= h_style;
      neg_x       <= h_negx;
      neg_y       <= h_negy;
      rem_x       <= {1'b0, h_ax};
      rem_y       <= {1'b0, h_ay};
      quo_x       <= '0;
      quo_y       <= '0;
      div_cnt     <= CntW'(FRAC_BITS);
    end else if (state == ST_DIV) begin
      rem_x   <= {newr_x[COORD_BITS-1:0], 1'b0};
      rem_y   <= {newr_y[COORD_BITS-1:0], 1'b0};
      quo_x   <= quo_x_next;
      quo_y   <= quo_y_next;
      div_cnt <= div_cnt - 1'b1;
      if (div_last) begin
        step_x <= neg_x ? (~mag_x + 1'b1) : mag_x;
        step_y <= neg_y ? (~mag_y + 1'b1) : mag_y;
      end
    end else if (emit && !is_last) begin
      pos_x       <= pos_x + {{(PosW - IncW){step_x[IncW-1]}}, step_x};
      pos_y       <= pos_y + {{(PosW - IncW){step_y[IncW-1]}}, step_y};
      point_index <= point_index + 1'b1;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x <= pos_x[PosW-1:FRAC_BITS];
      pixel_y <= pos_y[PosW-1:FRAC_BITS];
      thick   <= (style_reg == STYLE_THICK);
      visible <= (style_reg == STYLE_SOLID) || (style_reg == STYLE_THICK) ||
                 !point_index[DASH_SHIFT];
      last    <= is_last;
    end
  end

  `DSL_NEVER(a_pop_empty, clk, rst, q_pop && q_status.empty, "pop from empty queue")
  `DSL_ASSERT(a_emit_active, clk, rst, emit |-> active && (state == ST_RUN), "point without line")
  `DSL_ASSERT(a_last_clears, clk, rst, emit && is_last |=> !active, "line still active after last")
  `DSL_ASSERT(a_index_bound, clk, rst, active && (state == ST_RUN) |-> point_index <= {1'b0, step_count}, "point index past step count")
  `DSL_ASSERT(a_quo_bound, clk, rst, div_last |-> quo_x_next <= {1'b1, {FRAC_BITS{1'b0}}} && quo_y_next <= {1'b1, {FRAC_BITS{1'b0}}}, "increment above one")

endmodule
`default_nettype wire

[rtl/dda_styled_line_generator_unit.sv]
`default_nettype none
// DDA line generator with solid, thick and dashed styles. A load word takes the two endpoints
// and a style and gives no output; each step word then gives one point, the last one marked,
// and a step word with no line in progress is dropped. Points come out at one per cycle while
// steps are queued and out_stall is low. A load holds the back end while the bit-serial
// divider forms the per-step increments; up to QUEUE_DEPTH words are taken in meanwhile.
module dda_styled_line_generator_unit import dsl_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [1:0]            line_style,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       visible,
  output logic                       thick,
  output logic                       last
);

  localparam int unsigned EntryW = 5 * COORD_BITS + 5;

  logic              push, pop;
  logic [EntryW-1:0] wr_entry, rd_entry;
  queue_status_t     q_status;

  dsl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_style (line_style),
    .q_status   (q_status),
    .push       (push),
    .entry      (wr_entry)
  );

  dsl_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .status  (q_status)
  );

  dsl_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (rd_entry),
    .q_status  (q_status),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .thick     (thick),
    .last      (last)
  );

endmodule
`default_nettype wire

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsl_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam logic [1:0] STYLE_DASHED   = 2'd2;
  localparam logic [1:0] STYLE_DASH_ALT = 2'd3;
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int HOLD_OFF_AT    = 400;
  localparam int RANDOM_WORDS   = 1650;
  localparam int MAX_REPORTS    = 10;

  typedef logic [CW+FW-1:0]     fix_pos_t;
  typedef logic signed [FW+1:0] fix_step_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          visible;
    logic          thick;
    logic          last;
  } point_t;

  class line_scoreboard;
    point_t    expected_points[$];
    fix_pos_t  pos_x;
    fix_pos_t  pos_y;
    fix_step_t step_x;
    fix_step_t step_y;
    logic [CW:0] point_index;
    logic [CW:0] step_count;
    logic [1:0]  style_reg;
    bit          active;
    int failures;
    int reported;
    int points_checked;
    int loads_seen;
    int lines_done;
    int dash_gaps;
    int thick_points;

    function new();
      pos_x = '0;
      pos_y = '0;
      step_x = '0;
      step_y = '0;
      point_index = '0;
      step_count = '0;
      style_reg = STYLE_SOLID;
      active = 1'b0;
    endfunction

    function fix_step_t increment(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW:0] steps);
      logic [CW-1:0] delta;
      fix_pos_t      mag;
      if (steps == 0) begin
        return '0;
      end
      delta = (b >= a) ? b - a : a - b;
      mag = (fix_pos_t'(delta) << FW) / fix_pos_t'(steps);
      return (b >= a) ? fix_step_t'(mag) : -fix_step_t'(mag);
    endfunction

    // returns 1 when the word loads a line or yields a point
    function bit note_word(logic req, logic [CW-1:0] sx, logic [CW-1:0] sy,
                           logic [CW-1:0] ex, logic [CW-1:0] ey, logic [1:0] style);
      logic [CW-1:0] ax;
      logic [CW-1:0] ay;
      point_t p;
      if (req == REQ_LOAD) begin
        ax = (ex >= sx) ? ex - sx : sx - ex;
        ay = (ey >= sy) ? ey - sy : sy - ey;
        step_count = {1'b0, ((ax > ay) ? ax : ay)};
        step_x = increment(sx, ex, step_count);
        step_y = increment(sy, ey, step_count);
        pos_x = fix_pos_t'(sx) << FW;
        pos_y = fix_pos_t'(sy) << FW;
        point_index = '0;
        style_reg = style;
        active = 1'b1;
        loads_seen++;
        return 1'b1;
      end
      if (!active) begin
        return 1'b0;
      end
      p.x = pos_x[CW+FW-1:FW];
      p.y = pos_y[CW+FW-1:FW];
      p.visible = 1'b1;
      p.thick = 1'b0;
      if (style_reg == STYLE_THICK) begin
        p.thick = 1'b1;
      end else if (style_reg == STYLE_DASHED || style_reg == STYLE_DASH_ALT) begin
        p.visible = ~point_index[DASH_SHIFT];
      end
      p.last = (point_index == step_count);
      expected_points.push_back(p);
      if (!p.visible) dash_gaps++;
      if (p.thick) thick_points++;
      if (p.last) begin
        active = 1'b0;
        lines_done++;
      end else begin
        pos_x = pos_x + {{(CW-2){step_x[FW+1]}}, step_x};
        pos_y = pos_y + {{(CW-2){step_y[FW+1]}}, step_y};
        point_index++;
      end
      return 1'b1;
    endfunction

    function void report(string what, point_t want, point_t got);
      failures++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("%0t: %s: expected x=%0d y=%0d vis=%0b thk=%0b last=%0b,",
                 $realtime, what, want.x, want.y, want.visible, want.thick, want.last);
        $display("  got x=%0d y=%0d vis=%0b thk=%0b last=%0b",
                 got.x, got.y, got.visible, got.thick, got.last);
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        report("point with nothing expected", '0, got);
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (got.x !== want.x || got.y !== want.y || got.visible !== want.visible ||
          got.thick !== want.thick || got.last !== want.last) begin
        report("point mismatch", want, got);
      end
    endfunction

    function void close_out();
      while (expected_points.size() != 0) begin
        report("point never delivered", expected_points.pop_front(), '0);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          req_type = REQ_LOAD;
  logic [CW-1:0] start_x = '0;
  logic [CW-1:0] start_y = '0;
  logic [CW-1:0] end_x = '0;
  logic [CW-1:0] end_y = '0;
  logic [1:0]    line_style = STYLE_SOLID;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic          visible;
  logic          thick;
  logic          last;

  line_scoreboard sb = new();
  int  words_taken;
  int  results_seen;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_off_done;

  dda_styled_line_generator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_style (line_style),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .visible    (visible),
    .thick      (thick),
    .last       (last)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CW-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > (1 << CW) - 1) return '1;
    return v[CW-1:0];
  endfunction

  task automatic send_word(input logic req, input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                           input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                           input logic [1:0] style, output bit effective);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    start_x    <= sx;
    start_y    <= sy;
    end_x      <= ex;
    end_y      <= ey;
    line_style <= style;
    do @(posedge clk); while (in_stall);
    words_taken++;
    effective = sb.note_word(req, sx, sy, ex, ey, style);
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [1:0] style);
    bit eff;
    send_word(REQ_LOAD, CW'(sx), CW'(sy), CW'(ex), CW'(ey), style, eff);
  endtask

  task automatic step_line(input int n, output int hits);
    bit eff;
    hits = 0;
    repeat (n) begin
      send_word(REQ_STEP, CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)),
                CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)),
                2'($urandom_range(0, 3)), eff);
      hits += int'(eff);
    end
  endtask

  // receiver: check accepted points, then choose next stall
  initial begin
    point_t got;
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{x: pixel_x, y: pixel_y, visible: visible, thick: thick, last: last};
        sb.check_point(got);
        results_seen++;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        hold = HOLD_OFF_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
          out_stall <= 1'b0;
        end else if (r < 90) begin
          out_stall <= 1'b1;
        end else if (r < 97) begin
          hold = $urandom_range(1, 5);
          out_stall <= 1'b1;
        end else begin
          hold = $urandom_range(10, 30);
          out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d points still expected",
               IDLE_LIMIT, sb.expected_points.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  counted;
    int  hits;
    int  sx, sy, ex, ey, span, npts, nsend, r;
    bit  eff;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed lines
    step_line(1, hits);
    load_line(0, 0, 0, 0, STYLE_SOLID);
    step_line(2, hits);
    load_line(1023, 1023, 1023, 1023, STYLE_THICK);
    step_line(1, hits);
    load_line(0, 0, 1023, 1023, STYLE_SOLID);
    step_line(3, hits);
    load_line(1023, 0, 0, 1023, STYLE_THICK);
    step_line(2, hits);
    load_line(20, 3, 12, 8, STYLE_DASH_ALT);
    step_line(10, hits);

    // random lines with some noise
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) == 0) no_gaps = ~no_gaps;
      r = $urandom_range(0, 99);
      if (r < 90) begin
        sx = $urandom_range(0, 1023);
        sy = $urandom_range(0, 1023);
        span = ($urandom_range(0, 99) < 3) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        ex = int'(clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span));
        ey = int'(clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span));
        npts = (((ex > sx) ? ex - sx : sx - ex) > ((ey > sy) ? ey - sy : sy - ey)) ?
               ((ex > sx) ? ex - sx : sx - ex) + 1 : ((ey > sy) ? ey - sy : sy - ey) + 1;
        load_line(sx, sy, ex, ey, 2'($urandom_range(0, 3)));
        counted++;
        nsend = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npts - 1) : npts;
        if (nsend == npts && $urandom_range(0, 99) < 15) nsend += $urandom_range(1, 2);
        step_line(nsend, hits);
        counted += hits;
      end else begin
        send_word(1'($urandom_range(0, 1)), CW'($urandom_range(0, 1023)),
                  CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)),
                  CW'($urandom_range(0, 1023)), 2'($urandom_range(0, 3)), eff);
        counted += int'(eff);
      end
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (FW + 8) @(posedge clk);
    sb.close_out();

    $display("covered %0d words, %0d loads, %0d lines run to their last point",
             words_taken, sb.loads_seen, sb.lines_done);
    $display("checked %0d points (%0d dash gaps, %0d thick), %0d failures",
             sb.points_checked, sb.dash_gaps, sb.thick_points, sb.failures);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dsl_pkg.sv
rtl/dsl_front.sv
rtl/dsl_queue.sv
rtl/dsl_back.sv
rtl/dda_styled_line_generator_unit.sv
sim/testbench.sv
